### sv/assert_macros.svh
// Assertion macros shared by the RTL of the obstacle stop unit.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define LHOS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define LHOS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### sv/lhos_pkg.sv
// Package for the lidar obstacle stop unit: register indexes, turn constants,
// the rotation angle table and the Q1.15 rounding helper. No dependencies.
`timescale 1ns / 1ps

package lhos_pkg;

    typedef enum logic [2:0] {
        CFG_ANGLE_MARGIN  = 3'd0,
        CFG_DISTANCE_MIN  = 3'd1,
        CFG_DISTANCE_MAX  = 3'd2,
        CFG_PERCENT_ON    = 3'd3,
        CFG_PERCENT_OFF   = 3'd4,
        CFG_ARENA_X_LIMIT = 3'd5,
        CFG_ARENA_Y_LIMIT = 3'd6
    } cfg_index_t;

    localparam int CORDIC_STEPS = 16;
    localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;
    localparam logic signed [18:0] FULL_TURN_CD    = 19'sd36000;
    localparam logic signed [18:0] HALF_TURN_CD    = 19'sd18000;
    localparam logic signed [18:0] QUARTER_TURN_CD = 19'sd9000;
    localparam logic signed [18:0] TRI_QUARTER_CD  = 19'sd27000;
    localparam logic [16:0] HIT_WEIGHT = 17'd50;
    localparam logic [15:0] COUNT_MAX  = 16'hFFFF;

    // Arc tangent of 2^-i in units of 1/256 centidegree.
    function automatic logic signed [24:0] atan_lut(input logic [3:0] idx);
        logic signed [24:0] v;
        case (idx)
            4'd0:    v = 25'sd1152000;
            4'd1:    v = 25'sd680065;
            4'd2:    v = 25'sd359328;
            4'd3:    v = 25'sd182400;
            4'd4:    v = 25'sd91554;
            4'd5:    v = 25'sd45822;
            4'd6:    v = 25'sd22916;
            4'd7:    v = 25'sd11459;
            4'd8:    v = 25'sd5730;
            4'd9:    v = 25'sd2865;
            4'd10:   v = 25'sd1432;
            4'd11:   v = 25'sd716;
            4'd12:   v = 25'sd358;
            4'd13:   v = 25'sd179;
            4'd14:   v = 25'sd90;
            4'd15:   v = 25'sd45;
            default: v = 25'sd0;
        endcase
        return v;
    endfunction

    // Rounds a Q4.30 value half up to Q1.15 and saturates it.
    function automatic logic signed [15:0] sat_q15(input logic signed [33:0] v);
        logic signed [33:0] t;
        logic signed [15:0] r;
        t = (v + 34'sd16384) >>> 15;
        if (t > 34'sd32767)
            r = 16'sh7FFF;
        else if (t < -34'sd32768)
            r = 16'sh8000;
        else
            r = t[15:0];
        return r;
    endfunction

endpackage

### sv/lidar_heading_obstacle_stop_unit.sv
// Top level of the lidar obstacle stop unit: sequencer, shared rotation unit and counters.
// Depends on lhos_pkg and assert_macros.svh.
`timescale 1ns / 1ps
//
//  channel   | handshake              | content
//  s_axis    | tvalid/tready          | tuser group_start, tdata point and pose
//  m_axis    | tvalid/tready          | tdata stop, counts, obstacle position
//  cfg       | cfg_we (no wait)       | cfg_addr register index, cfg_data value
//
//  The sequencer takes a word from acceptance to its result through the two
//  16-step passes through the one shared rotation unit and one reduction step for
//  each turn taken off the angle sum; a point next to the target goes straight to
//  the result. The input is ready only while the sequencer is idle, and a waiting
//  result does not block the next word until that one is done.
//  Reset is asynchronous and active low, and loads the register defaults.

`include "assert_macros.svh"

module lidar_heading_obstacle_stop_unit (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // point_angle[15:0], point_distance[31:16], robot_x[47:32], robot_y[63:48],
    // robot_heading[81:64], goal_x[97:82], goal_y[113:98], zero[119:114]
    input  logic [119:0] s_axis_tdata,
    // group_start[0]
    input  logic         s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // stop_out[0], hits_out[16:1], misses_out[32:17], obstacle_x[48:33],
    // obstacle_y[64:49], zero[71:65]
    output logic [71:0]  m_axis_tdata,
    input  logic         cfg_we,
    input  logic [2:0]   cfg_addr,
    input  logic [15:0]  cfg_data
);
    import lhos_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE, ST_DEG, ST_DEGFIX, ST_THETA, ST_REDUCE, ST_FOLD, ST_SC_ITER,
        ST_SC_DONE, ST_PROJ_X, ST_PROJ_Y, ST_AT_INIT, ST_AT_ITER, ST_TGT,
        ST_WIN, ST_CNT, ST_PCT, ST_DONE
    } state_t;

    state_t state_reg;
    logic [3:0]  iter_reg;
    logic        out_valid_reg;
    logic [71:0] out_data_reg;

    logic [7:0]  margin_reg;
    logic [15:0] dmin_reg, dmax_reg;
    logic [6:0]  pon_reg, poff_reg;
    logic [14:0] arena_x_reg, arena_y_reg;

    logic        stop_reg;
    logic [15:0] hits_reg, misses_reg;
    logic [15:0] obs_x_reg, obs_y_reg;

    logic [15:0] ang_reg, dist_reg;
    logic signed [15:0] rx_reg, ry_reg;
    logic signed [17:0] hd_reg;
    logic signed [16:0] dx_reg, dy_reg;
    logic [9:0]  deg_reg;
    logic [16:0] pa_reg;
    logic signed [18:0] theta_reg;
    logic        neg_reg, sc_mode_reg;
    logic signed [33:0] cx_reg, cy_reg;
    logic signed [24:0] cz_reg;
    logic signed [15:0] sin_reg, cos_reg, base_reg;
    logic signed [18:0] lx_reg, ly_reg, tgt_reg;
    logic        count_reg, hit_reg;

    logic               accept;
    logic signed [16:0] in_dx, in_dy;
    logic               near;
    logic [28:0]        deg_prod;
    logic [16:0]        deg_rem;
    logic signed [18:0] fold_r;
    logic               fold_neg;
    logic signed [33:0] cx_sh, cy_sh, nx, ny, xf;
    logic signed [24:0] nz, at_step;
    logic               dir;
    logic signed [15:0] mul_trig, mul_base;
    logic signed [32:0] mul_prod, proj_off;
    logic signed [18:0] proj;
    logic signed [16:0] at_xx, at_yy;
    logic signed [18:0] tgt_raw, margin_cd, down_raw, top_raw, down_w, top_w, pa_s;
    logic               in_win, in_arena, is_hit;
    logic [16:0]        hit_sum, cnt_sum;
    logic [24:0]        hit100, miss100, on_rhs, off_rhs;
    logic               on_cond, off_cond;

    assign accept        = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    always_comb
    begin
        in_dx = 17'(signed'(s_axis_tdata[97:82])) - 17'(signed'(s_axis_tdata[47:32]));
        in_dy = 17'(signed'(s_axis_tdata[113:98])) - 17'(signed'(s_axis_tdata[63:48]));
        near  = (in_dx >= -17'sd1) && (in_dx <= 17'sd1) && (in_dy >= -17'sd1)
                && (in_dy <= 17'sd1) && ((in_dx == 17'sd0) || (in_dy == 17'sd0));

        deg_prod = 29'(ang_reg) * 29'd5242;
        deg_rem  = 17'(ang_reg) - 17'(17'(deg_reg) * 17'd100);

        fold_neg = 1'b0;
        if (theta_reg > TRI_QUARTER_CD)
            fold_r = theta_reg - FULL_TURN_CD;
        else if (theta_reg > QUARTER_TURN_CD)
        begin
            fold_r   = theta_reg - HALF_TURN_CD;
            fold_neg = 1'b1;
        end
        else
            fold_r = theta_reg;

        cx_sh   = cx_reg >>> iter_reg;
        cy_sh   = cy_reg >>> iter_reg;
        at_step = atan_lut(iter_reg);
        dir     = sc_mode_reg ? !cz_reg[24] : cy_reg[33];
        if (dir)
        begin
            nx = cx_reg - cy_sh;
            ny = cy_reg + cx_sh;
            nz = cz_reg - at_step;
        end
        else
        begin
            nx = cx_reg + cy_sh;
            ny = cy_reg - cx_sh;
            nz = cz_reg + at_step;
        end
        xf = neg_reg ? -cx_reg : cx_reg;

        mul_trig = (state_reg == ST_PROJ_X) ? sin_reg : cos_reg;
        mul_base = (state_reg == ST_PROJ_X) ? rx_reg : ry_reg;
        mul_prod = 33'(mul_trig) * $signed({17'd0, dist_reg});
        proj_off = (mul_prod + 33'sd16384) >>> 15;
        proj     = 19'(mul_base) + 19'(proj_off);

        at_xx = dy_reg[16] ? -dy_reg : dy_reg;
        at_yy = dy_reg[16] ? -dx_reg : dx_reg;

        tgt_raw   = 19'(base_reg) + 19'((cz_reg + 25'sd128) >>> 8) - 19'(hd_reg);
        margin_cd = $signed({4'd0, 15'(15'(margin_reg) * 15'd100)});
        down_raw  = tgt_reg - margin_cd;
        top_raw   = tgt_reg + margin_cd;
        down_w    = (down_raw < 19'sd0) ? down_raw + FULL_TURN_CD : down_raw;
        top_w     = (top_raw > FULL_TURN_CD) ? top_raw - FULL_TURN_CD : top_raw;
        pa_s      = $signed({2'b00, pa_reg});
        if (top_w > down_w)
            in_win = (pa_s <= top_w) && (pa_s >= down_w);
        else
            in_win = (pa_s <= top_w) || (pa_s >= down_w);
        in_arena = (lx_reg > 19'sd0) && (lx_reg < $signed({4'd0, arena_x_reg}))
                   && (ly_reg > 19'sd0) && (ly_reg < $signed({4'd0, arena_y_reg}));
        is_hit   = (dist_reg > dmin_reg) && (dist_reg < dmax_reg);

        hit_sum  = 17'(hits_reg) + HIT_WEIGHT;
        cnt_sum  = 17'(hits_reg) + 17'(misses_reg);
        hit100   = 25'(hits_reg) * 25'd100;
        miss100  = 25'(misses_reg) * 25'd100;
        on_rhs   = 25'({1'b0, pon_reg} + 8'd1) * 25'(cnt_sum);
        off_rhs  = 25'({1'b0, poff_reg} + 8'd1) * 25'(cnt_sum);
        on_cond  = hit100 >= on_rhs;
        off_cond = miss100 >= off_rhs;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            iter_reg      <= 4'd0;
            out_valid_reg <= 1'b0;
            margin_reg    <= 8'd30;
            dmin_reg      <= 16'd100;
            dmax_reg      <= 16'd500;
            pon_reg       <= 7'd50;
            poff_reg      <= 7'd50;
            arena_x_reg   <= 15'd2900;
            arena_y_reg   <= 15'd1900;
            stop_reg      <= 1'b0;
            hits_reg      <= 16'd0;
            misses_reg    <= 16'd0;
            obs_x_reg     <= 16'd0;
            obs_y_reg     <= 16'd0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index_t'(cfg_addr))
                    CFG_ANGLE_MARGIN:  margin_reg  <= cfg_data[7:0];
                    CFG_DISTANCE_MIN:  dmin_reg    <= cfg_data;
                    CFG_DISTANCE_MAX:  dmax_reg    <= cfg_data;
                    CFG_PERCENT_ON:    pon_reg     <= cfg_data[6:0];
                    CFG_PERCENT_OFF:   poff_reg    <= cfg_data[6:0];
                    CFG_ARENA_X_LIMIT: arena_x_reg <= cfg_data[14:0];
                    CFG_ARENA_Y_LIMIT: arena_y_reg <= cfg_data[14:0];
                    default: ;
                endcase
            end

            if (out_valid_reg && m_axis_tready && state_reg != ST_DONE)
                out_valid_reg <= 1'b0;

            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        if (s_axis_tuser)
                        begin
                            hits_reg   <= 16'd0;
                            misses_reg <= 16'd0;
                        end
                        if (near)
                        begin
                            stop_reg  <= 1'b0;
                            state_reg <= ST_DONE;
                        end
                        else
                            state_reg <= ST_DEG;
                    end
                end
                ST_DEG:     state_reg <= ST_DEGFIX;
                ST_DEGFIX:  state_reg <= ST_THETA;
                ST_THETA:   state_reg <= ST_REDUCE;
                ST_REDUCE:
                begin
                    if (theta_reg >= 19'sd0 && theta_reg < FULL_TURN_CD)
                        state_reg <= ST_FOLD;
                end
                ST_FOLD:
                begin
                    iter_reg  <= 4'd0;
                    state_reg <= ST_SC_ITER;
                end
                ST_SC_ITER:
                begin
                    iter_reg <= iter_reg + 4'd1;
                    if (iter_reg == 4'(CORDIC_STEPS - 1))
                        state_reg <= ST_SC_DONE;
                end
                ST_SC_DONE: state_reg <= ST_PROJ_X;
                ST_PROJ_X:  state_reg <= ST_PROJ_Y;
                ST_PROJ_Y:  state_reg <= ST_AT_INIT;
                ST_AT_INIT:
                begin
                    iter_reg  <= 4'd0;
                    state_reg <= ST_AT_ITER;
                end
                ST_AT_ITER:
                begin
                    iter_reg <= iter_reg + 4'd1;
                    if (iter_reg == 4'(CORDIC_STEPS - 1))
                        state_reg <= ST_TGT;
                end
                ST_TGT:     state_reg <= ST_WIN;
                ST_WIN:     state_reg <= ST_CNT;
                ST_CNT:
                begin
                    if (count_reg && hit_reg)
                    begin
                        hits_reg  <= hit_sum[16] ? COUNT_MAX : hit_sum[15:0];
                        obs_x_reg <= lx_reg[15:0];
                        obs_y_reg <= ly_reg[15:0];
                    end
                    else if (count_reg && misses_reg != COUNT_MAX)
                        misses_reg <= misses_reg + 16'd1;
                    state_reg <= ST_PCT;
                end
                ST_PCT:
                begin
                    if (cnt_sum != 17'd0)
                        stop_reg <= (stop_reg || on_cond) && !off_cond;
                    state_reg <= ST_DONE;
                end
                ST_DONE:
                begin
                    if (!out_valid_reg || m_axis_tready)
                    begin
                        out_data_reg  <= {7'd0, obs_y_reg, obs_x_reg, misses_reg,
                                          hits_reg, stop_reg};
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:    state_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                ang_reg  <= s_axis_tdata[15:0];
                dist_reg <= s_axis_tdata[31:16];
                rx_reg   <= s_axis_tdata[47:32];
                ry_reg   <= s_axis_tdata[63:48];
                hd_reg   <= s_axis_tdata[81:64];
                dx_reg   <= in_dx;
                dy_reg   <= in_dy;
            end
            ST_DEG:     deg_reg <= deg_prod[28:19];
            ST_DEGFIX:
            begin
                if (deg_rem >= 17'd100)
                    deg_reg <= deg_reg + 10'd1;
            end
            ST_THETA:
            begin
                pa_reg    <= 17'(17'(deg_reg) * 17'd100);
                theta_reg <= $signed({2'b00, 17'(17'(deg_reg) * 17'd100)}) + 19'(hd_reg);
            end
            ST_REDUCE:
            begin
                if (theta_reg < 19'sd0)
                    theta_reg <= theta_reg + FULL_TURN_CD;
                else if (theta_reg >= FULL_TURN_CD)
                    theta_reg <= theta_reg - FULL_TURN_CD;
            end
            ST_FOLD:
            begin
                neg_reg     <= fold_neg;
                sc_mode_reg <= 1'b1;
                cx_reg      <= CORDIC_GAIN_Q30;
                cy_reg      <= 34'sd0;
                cz_reg      <= 25'(fold_r) <<< 8;
            end
            ST_SC_ITER, ST_AT_ITER:
            begin
                cx_reg <= nx;
                cy_reg <= ny;
                cz_reg <= nz;
            end
            ST_SC_DONE:
            begin
                sin_reg <= sat_q15(neg_reg ? -cy_reg : cy_reg);
                cos_reg <= sat_q15(xf);
            end
            ST_PROJ_X:  lx_reg <= proj;
            ST_PROJ_Y:  ly_reg <= proj;
            ST_AT_INIT:
            begin
                sc_mode_reg <= 1'b0;
                cx_reg      <= 34'(at_xx) <<< 14;
                cy_reg      <= 34'(at_yy) <<< 14;
                cz_reg      <= 25'sd0;
                if (dy_reg[16])
                    base_reg <= dx_reg[16] ? -16'sd18000 : 16'sd18000;
                else
                    base_reg <= 16'sd0;
            end
            ST_TGT:
            begin
                tgt_reg <= (tgt_raw < 19'sd0) ? tgt_raw + FULL_TURN_CD : tgt_raw;
            end
            ST_WIN:
            begin
                count_reg <= in_arena && in_win;
                hit_reg   <= is_hit;
            end
            default: ;
        endcase
    end

    `LHOS_ASSERT(a_sc_pass_ends, (state_reg == ST_SC_ITER && iter_reg == 4'd15) |=> (state_reg == ST_SC_DONE), "sine pass did not end after its last step")
    `LHOS_ASSERT(a_pending_held, (state_reg == ST_DONE && m_axis_tvalid && !m_axis_tready) |=> (state_reg == ST_DONE && m_axis_tvalid), "result overwrote a waiting word")
    `LHOS_ASSERT(a_busy_after_accept, (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready, "input ready while a word is in work")
    `LHOS_ASSERT_ALWAYS(a_reset_idle, !rst_n |-> (state_reg == ST_IDLE && !m_axis_tvalid), "sequencer not idle in reset")

endmodule

### tb/tb_lidar_heading_obstacle_stop_unit.sv
// Self-checking testbench for the lidar obstacle stop unit: drives lidar points with pose and
// target, predicts stop flag, counts and obstacle position, and compares every result word.
// Depends on lhos_pkg and the unit's RTL.
`timescale 1ns / 1ps

class stop_scoreboard;
    typedef struct {
        logic        stop;
        logic [15:0] hits;
        logic [15:0] misses;
        logic [15:0] obs_x;
        logic [15:0] obs_y;
    } status_t;

    status_t pending_status[$];
    int      error_count;

    // Predictor state and register copies.
    longint  margin, dmin, dmax, pct_on, pct_off, xlim, ylim;
    bit      stop_flag;
    longint  hit_count, miss_count, obs_x, obs_y;

    function new();
        margin = 30;
        dmin = 100;
        dmax = 500;
        pct_on = 50;
        pct_off = 50;
        xlim = 2900;
        ylim = 1900;
        stop_flag = 0;
        hit_count = 0;
        miss_count = 0;
        obs_x = 0;
        obs_y = 0;
        error_count = 0;
    endfunction

    function void write_reg(lhos_pkg::cfg_index_t idx, logic [15:0] value);
        case (idx)
            lhos_pkg::CFG_ANGLE_MARGIN:  margin = longint'(value[7:0]);
            lhos_pkg::CFG_DISTANCE_MIN:  dmin = longint'(value);
            lhos_pkg::CFG_DISTANCE_MAX:  dmax = longint'(value);
            lhos_pkg::CFG_PERCENT_ON:    pct_on = longint'(value[6:0]);
            lhos_pkg::CFG_PERCENT_OFF:   pct_off = longint'(value[6:0]);
            lhos_pkg::CFG_ARENA_X_LIMIT: xlim = longint'(value[14:0]);
            lhos_pkg::CFG_ARENA_Y_LIMIT: ylim = longint'(value[14:0]);
            default: ;
        endcase
    endfunction

    static function longint shift_down(longint v, int s);
        longint q;
        if (v >= 0)
            q = v >>> s;
        else
            q = -((-v + (longint'(1) << s) - 1) >>> s);
        return q;
    endfunction

    static function longint arc_step(int i);
        longint tab[16] = '{1152000, 680065, 359328, 182400, 91554, 45822, 22916, 11459,
                            5730, 2865, 1432, 716, 358, 179, 90, 45};
        return tab[i];
    endfunction

    static function longint round_q15(longint v);
        longint r;
        r = shift_down(v + 16384, 15);
        if (r > 32767)
            r = 32767;
        if (r < -32768)
            r = -32768;
        return r;
    endfunction

    static function void rotate(longint theta, output longint s, output longint c);
        longint r, x, y, z, t;
        bit     flip;
        r = theta % 36000;
        x = 652032874;
        y = 0;
        flip = 0;
        if (r < 0)
            r += 36000;
        if (r > 27000)
            r -= 36000;
        else if (r > 9000)
        begin
            r -= 18000;
            flip = 1;
        end
        z = r * 256;
        for (int i = 0; i < 16; i++)
        begin
            if (z >= 0)
            begin
                t = x - shift_down(y, i);
                y = y + shift_down(x, i);
                z -= arc_step(i);
            end
            else
            begin
                t = x + shift_down(y, i);
                y = y - shift_down(x, i);
                z += arc_step(i);
            end
            x = t;
        end
        if (flip)
        begin
            x = -x;
            y = -y;
        end
        s = round_q15(y);
        c = round_q15(x);
    endfunction

    static function longint bearing(longint yy, longint xx);
        longint base, x, y, z, t;
        base = 0;
        z = 0;
        if (xx < 0)
        begin
            base = (yy >= 0) ? 18000 : -18000;
            xx = -xx;
            yy = -yy;
        end
        x = xx * 16384;
        y = yy * 16384;
        for (int i = 0; i < 16; i++)
        begin
            if (y < 0)
            begin
                t = x - shift_down(y, i);
                y = y + shift_down(x, i);
                z -= arc_step(i);
            end
            else
            begin
                t = x + shift_down(y, i);
                y = y - shift_down(x, i);
                z += arc_step(i);
            end
            x = t;
        end
        return base + shift_down(z + 128, 8);
    endfunction

    function void note_point(logic [119:0] d, logic grp);
        longint pa, range_mm, rx, ry, hd, dx, dy, s, c, lx, ly, tgt, down, top, m, sum;
        bit     in_win;
        status_t st;
        pa = (longint'(d[15:0]) / 100) * 100;
        range_mm = longint'(d[31:16]);
        rx = longint'($signed(d[47:32]));
        ry = longint'($signed(d[63:48]));
        hd = longint'($signed(d[81:64]));
        dx = longint'($signed(d[97:82])) - rx;
        dy = longint'($signed(d[113:98])) - ry;
        if (grp)
        begin
            hit_count = 0;
            miss_count = 0;
        end
        if (dx * dx + dy * dy <= 1)
            stop_flag = 0;
        else
        begin
            m = margin * 100;
            rotate(pa + hd, s, c);
            lx = rx + shift_down(s * range_mm + 16384, 15);
            ly = ry + shift_down(c * range_mm + 16384, 15);
            tgt = bearing(dx, dy) - hd;
            if (tgt < 0)
                tgt += 36000;
            down = tgt - m;
            top = tgt + m;
            if (down < 0)
                down += 36000;
            if (top > 36000)
                top -= 36000;
            if (top > down)
                in_win = (pa <= top && pa >= down);
            else
                in_win = (pa <= top || pa >= down);
            if (lx > 0 && lx < xlim && ly > 0 && ly < ylim && in_win)
            begin
                if (range_mm > dmin && range_mm < dmax)
                begin
                    hit_count = (hit_count + 50 > 65535) ? 65535 : hit_count + 50;
                    obs_x = lx;
                    obs_y = ly;
                end
                else if (miss_count < 65535)
                    miss_count++;
            end
            sum = (hit_count + miss_count) & 32'hFFFF_FFFF;
            if (sum != 0)
            begin
                if ((hit_count * 100) / sum > pct_on && !stop_flag)
                    stop_flag = 1;
                if ((miss_count * 100) / sum > pct_off && stop_flag)
                    stop_flag = 0;
            end
        end
        st.stop = stop_flag;
        st.hits = hit_count[15:0];
        st.misses = miss_count[15:0];
        st.obs_x = obs_x[15:0];
        st.obs_y = obs_y[15:0];
        pending_status.push_back(st);
    endfunction

    task report(string what, logic [15:0] got, logic [15:0] want);
        $display("MISMATCH %s: got %0h expected %0h", what, got, want);
        error_count++;
    endtask

    task check_status(logic [71:0] w);
        status_t st;
        if (pending_status.size() == 0)
        begin
            report("unexpected word", w[15:0], 16'd0);
            return;
        end
        st = pending_status.pop_front();
        if (w[0] !== st.stop)
            report("stop_out", 16'(w[0]), 16'(st.stop));
        if (w[16:1] !== st.hits)
            report("hits_out", w[16:1], st.hits);
        if (w[32:17] !== st.misses)
            report("misses_out", w[32:17], st.misses);
        if (w[48:33] !== st.obs_x)
            report("obstacle_x", w[48:33], st.obs_x);
        if (w[64:49] !== st.obs_y)
            report("obstacle_y", w[64:49], st.obs_y);
    endtask
endclass

module tb_lidar_heading_obstacle_stop_unit;
    import lhos_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [119:0] s_axis_tdata;
    logic         s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [71:0]  m_axis_tdata;
    logic         cfg_we;
    logic [2:0]   cfg_addr;
    logic [15:0]  cfg_data;

    stop_scoreboard sb;
    int  idle_cycles;
    bit  hold_sink;
    bit  sink_free;

    lidar_heading_obstacle_stop_unit u_top (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 0;
        forever #10 clk = ~clk;
    end

    function automatic int gap_len();
        int g;
        if ($urandom_range(0, 19) == 0)
            g = $urandom_range(20, 120);
        else
            g = $urandom_range(0, 3);
        return g;
    endfunction

    // The valid line stays high after an accepted word unless a gap follows.
    task automatic send_point(logic grp, logic [15:0] ang, logic [15:0] dist_mm,
                              logic [15:0] rx, logic [15:0] ry, logic [17:0] hd,
                              logic [15:0] gx, logic [15:0] gy, bit gaps);
        int g;
        g = gaps ? gap_len() : 0;
        if (g != 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= grp;
        s_axis_tdata <= {6'd0, gy, gx, hd, ry, rx, dist_mm, ang};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sb.note_point({6'd0, gy, gx, hd, ry, rx, dist_mm, ang}, grp);
    endtask

    task automatic write_reg(cfg_index_t idx, logic [15:0] value);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= value;
        @(posedge clk);
        sb.write_reg(idx, value);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.pending_status.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    // Random point with the robot mostly inside the arena, so counts move.
    task automatic random_point(bit gaps);
        logic [15:0] rx, ry, gx, gy, ang, dist_mm;
        logic [17:0] hd;
        int sel;
        sel = $urandom_range(0, 9);
        rx = 16'($urandom_range(200, 2700));
        ry = 16'($urandom_range(200, 1700));
        gx = 16'($urandom_range(0, 2900));
        gy = 16'($urandom_range(0, 1900));
        hd = 18'($signed($urandom_range(0, 144000)) - 72000);
        ang = 16'($urandom_range(0, 35999));
        dist_mm = 16'($urandom_range(0, 700));
        if (sel == 0)
        begin
            rx = 16'($urandom);
            ry = 16'($urandom);
            gx = 16'($urandom);
            gy = 16'($urandom);
            ang = 16'($urandom);
            dist_mm = 16'($urandom);
            hd = 18'($urandom);
        end
        else if (sel == 1)
        begin
            gx = rx + 16'($urandom_range(0, 2)) - 16'd1;
            gy = ry;
        end
        send_point($urandom_range(0, 15) == 0, ang, dist_mm, rx, ry, hd, gx, gy, gaps);
    endtask

    initial
    begin
        sb = new();
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = 1'b0;
        cfg_we = 1'b0;
        cfg_addr = CFG_ANGLE_MARGIN;
        cfg_data = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_point(1, 16'd0, 16'd300, 16'd1000, 16'd500, 18'd0, 16'd1000, 16'd1500, 0);
        send_point(0, 16'd35999, 16'd65535, 16'h8000, 16'h7FFF, 18'h3FFFF, 16'h7FFF, 16'h8000, 0);
        send_point(0, 16'd65535, 16'd0, 16'h7FFF, 16'h8000, 18'(-72000), 16'h8000, 16'h7FFF, 0);
        send_point(0, 16'd100, 16'd250, 16'd1000, 16'd1000, 18'd72000, 16'd1000, 16'd1000, 0);
        send_point(0, 16'd100, 16'd250, 16'd1000, 16'd1000, 18'd0, 16'd1001, 16'd1000, 0);
        send_point(0, 16'd100, 16'd250, 16'd1000, 16'd1000, 18'd0, 16'd1001, 16'd1001, 0);
        send_point(0, 16'd18000, 16'd101, 16'd1500, 16'd1500, 18'd18000, 16'd1500, 16'd500, 0);
        send_point(0, 16'd35950, 16'd499, 16'd1500, 16'd500, 18'd0, 16'd1500, 16'd1500, 0);
        send_point(0, 16'd200, 16'd400, 16'd1500, 16'd500, 18'd0, 16'd1500, 16'd1500, 0);
        send_point(1, 16'd9000, 16'd300, 16'd500, 16'd1000, 18'd9000, 16'd1500, 16'd1000, 0);
        send_point(0, 16'd27000, 16'd300, 16'd2500, 16'd1000, 18'(-9000), 16'd100, 16'd1000, 0);
        send_point(0, 16'd100, 16'd600, 16'd1500, 16'd500, 18'd0, 16'd1500, 16'd1500, 0);
        drain();

        for (int phase = 0; phase < 5; phase++)
        begin
            case (phase)
                0:
                begin
                    write_reg(CFG_ANGLE_MARGIN, 16'd180);
                    write_reg(CFG_DISTANCE_MIN, 16'd0);
                    write_reg(CFG_DISTANCE_MAX, 16'd65535);
                    write_reg(CFG_PERCENT_ON, 16'd0);
                    write_reg(CFG_PERCENT_OFF, 16'd100);
                    write_reg(CFG_ARENA_X_LIMIT, 16'd32767);
                    write_reg(CFG_ARENA_Y_LIMIT, 16'd32767);
                end
                1:
                begin
                    write_reg(CFG_ANGLE_MARGIN, 16'd0);
                    write_reg(CFG_DISTANCE_MIN, 16'd65535);
                    write_reg(CFG_DISTANCE_MAX, 16'd0);
                    write_reg(CFG_PERCENT_ON, 16'd100);
                    write_reg(CFG_PERCENT_OFF, 16'd0);
                    write_reg(CFG_ARENA_X_LIMIT, 16'd0);
                    write_reg(CFG_ARENA_Y_LIMIT, 16'd0);
                end
                default:
                begin
                    write_reg(CFG_ANGLE_MARGIN, 16'($urandom_range(10, 180)));
                    write_reg(CFG_DISTANCE_MIN, 16'($urandom_range(0, 300)));
                    write_reg(CFG_DISTANCE_MAX, 16'($urandom_range(300, 700)));
                    write_reg(CFG_PERCENT_ON, 16'($urandom_range(0, 100)));
                    write_reg(CFG_PERCENT_OFF, 16'($urandom_range(0, 100)));
                    write_reg(CFG_ARENA_X_LIMIT, 16'($urandom_range(1000, 32767)));
                    write_reg(CFG_ARENA_Y_LIMIT, 16'($urandom_range(1000, 32767)));
                end
            endcase
            if (phase == 2)
            begin
                hold_sink = 1'b1;
                for (int i = 0; i < 6; i++)
                    random_point(0);
            end
            for (int i = 0; i < (phase < 2 ? 40 : 140); i++)
                random_point(i % 50 < 35);
            drain();
        end

        if (sb.error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        m_axis_tready = 1'b0;
        sink_free = 1'b1;
        forever
        begin
            @(posedge clk);
            if (hold_sink)
            begin
                hold_sink = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (400) @(posedge clk);
            end
            if ($urandom_range(0, 99) < 2)
                sink_free = ~sink_free;
            m_axis_tready <= sink_free ? 1'b1 : ($urandom_range(0, 3) == 0);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_status(m_axis_tdata);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end
endmodule
